@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL; clk and rst come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MCK_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication.
`define MCK_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

@@ sv/mck_pkg.sv @@
package mck_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  localparam logic [3:0] DashReset = 4'd3;
  localparam logic [3:0] LetterGapReset = 4'd3;
  localparam logic [4:0] WordGapReset = 5'd6;
  localparam logic [7:0] PauseReset = 8'd50;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] DigitBase = 8'd26;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DASH,
    CFG_LETTER_GAP,
    CFG_WORD_GAP,
    CFG_PAUSE
  } cfg_idx_t;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    S_FETCH,
    S_LGAP,
    S_ELEM,
    S_EGAP,
    S_SPACE,
    S_EOMCHK,
    S_PAUSE
  } step_t;

  typedef enum logic [2:0] {
    DUR_ONE,
    DUR_ELEM,
    DUR_LGAP,
    DUR_WGAP,
    DUR_PAUSE
  } dur_sel_t;

  typedef enum logic [1:0] {
    LAST_NEVER,
    LAST_ELEM,
    LAST_NO_EOM,
    LAST_ALWAYS
  } last_sel_t;

  typedef enum logic [1:0] {
    BR_JUMP,
    BR_DISPATCH,
    BR_ELEM,
    BR_EOM
  } branch_t;

  typedef enum logic [1:0] {
    PWL_KEEP,
    PWL_CLASS,
    PWL_CLEAR
  } pwl_op_t;

  typedef struct packed {
    logic      emit;
    logic      level;
    dur_sel_t  dur;
    last_sel_t last_sel;
    branch_t   br;
    pwl_op_t   pwl;
    step_t     target;
  } ucw_t;

  // Morse code: element count and pattern, element 0 in bit 0, 1 = dash.
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  function automatic ucw_t mck_ucode(input step_t step);
    ucw_t cw;
    cw = '{emit: 1'b0, level: 1'b0, dur: DUR_ONE, last_sel: LAST_NEVER,
           br: BR_JUMP, pwl: PWL_KEEP, target: S_FETCH};
    case (step)
      S_FETCH: begin
        cw.br = BR_DISPATCH;
        cw.pwl = PWL_CLASS;
      end
      S_LGAP: begin
        cw.emit = 1'b1;
        cw.dur = DUR_LGAP;
        cw.target = S_ELEM;
      end
      S_ELEM: begin
        cw.emit = 1'b1;
        cw.level = 1'b1;
        cw.dur = DUR_ELEM;
        cw.last_sel = LAST_ELEM;
        cw.br = BR_ELEM;
      end
      S_EGAP: begin
        cw.emit = 1'b1;
        cw.target = S_ELEM;
      end
      S_SPACE: begin
        cw.emit = 1'b1;
        cw.dur = DUR_WGAP;
        cw.last_sel = LAST_NO_EOM;
        cw.target = S_EOMCHK;
      end
      S_EOMCHK: begin
        cw.br = BR_EOM;
      end
      S_PAUSE: begin
        cw.emit = 1'b1;
        cw.dur = DUR_PAUSE;
        cw.last_sel = LAST_ALWAYS;
        cw.pwl = PWL_CLEAR;
      end
      default: begin
        cw.target = S_FETCH;
      end
    endcase
    return cw;
  endfunction

  function automatic code_t mck_code(input logic [5:0] idx);
    code_t c;
    case (idx)
      6'd0:  c = '{3'd2, 5'b00010};
      6'd1:  c = '{3'd4, 5'b00001};
      6'd2:  c = '{3'd4, 5'b00101};
      6'd3:  c = '{3'd3, 5'b00001};
      6'd4:  c = '{3'd1, 5'b00000};
      6'd5:  c = '{3'd4, 5'b00100};
      6'd6:  c = '{3'd3, 5'b00011};
      6'd7:  c = '{3'd4, 5'b00000};
      6'd8:  c = '{3'd2, 5'b00000};
      6'd9:  c = '{3'd4, 5'b01110};
      6'd10: c = '{3'd3, 5'b00101};
      6'd11: c = '{3'd4, 5'b00010};
      6'd12: c = '{3'd2, 5'b00011};
      6'd13: c = '{3'd2, 5'b00001};
      6'd14: c = '{3'd3, 5'b00111};
      6'd15: c = '{3'd4, 5'b00110};
      6'd16: c = '{3'd4, 5'b01011};
      6'd17: c = '{3'd3, 5'b00010};
      6'd18: c = '{3'd3, 5'b00000};
      6'd19: c = '{3'd1, 5'b00001};
      6'd20: c = '{3'd3, 5'b00100};
      6'd21: c = '{3'd4, 5'b01000};
      6'd22: c = '{3'd3, 5'b00110};
      6'd23: c = '{3'd4, 5'b01001};
      6'd24: c = '{3'd4, 5'b01101};
      6'd25: c = '{3'd4, 5'b00011};
      6'd26: c = '{3'd5, 5'b11111};
      6'd27: c = '{3'd5, 5'b11110};
      6'd28: c = '{3'd5, 5'b11100};
      6'd29: c = '{3'd5, 5'b11000};
      6'd30: c = '{3'd5, 5'b10000};
      6'd31: c = '{3'd5, 5'b00000};
      6'd32: c = '{3'd5, 5'b00001};
      6'd33: c = '{3'd5, 5'b00011};
      6'd34: c = '{3'd5, 5'b00111};
      6'd35: c = '{3'd5, 5'b01111};
      default: c = '{3'd1, 5'b00000};
    endcase
    return c;
  endfunction

endpackage

@@ sv/mck_in_if.sv @@
interface mck_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_message;

  modport source(output valid, character, end_of_message, input ready);
  modport sink(input valid, character, end_of_message, output ready);
endinterface

@@ sv/mck_out_if.sv @@
interface mck_out_if;
  logic       valid;
  logic       ready;
  logic       level;
  logic [7:0] duration_units;
  logic       last;

  modport source(output valid, level, duration_units, last, input ready);
  modport sink(input valid, level, duration_units, last, output ready);
endinterface

@@ sv/mck_cfg_if.sv @@
interface mck_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mck_pkg::CfgIdxW-1:0]  index;
  logic [mck_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/morse_code_keyer.sv @@
// Morse keyer: takes one ASCII character per transaction on chars (A-Z, 0-9 and
// space are recognized, anything else is dropped) and sends key segments on segs,
// each a level, a duration in dot units and a last mark on the final segment of
// that character. A microprogram of seven control words, stepped one word per
// clock while segs does not stall an emitting word and, at fetch, a character
// is waiting, drives the datapath; an end-of-message flag adds a pause segment.
// A new character is taken only when the sequencer is back at its fetch step.
// The four timing registers are written through cfg, which is always ready.
`include "assert_macros.svh"

module morse_code_keyer (
  input  logic        clk,
  input  logic        rst,
  mck_in_if.sink      chars,
  mck_out_if.source   segs,
  mck_cfg_if.sink     cfg
);

  // Timing registers.
  logic [3:0] dash_units;
  logic [3:0] letter_gap_units;
  logic [4:0] word_gap_units;
  logic [7:0] pause_units;

  // Sequencer and datapath state.
  mck_pkg::step_t step, step_next;
  mck_pkg::ucw_t  cw;
  logic           adv;
  logic           out_free;
  logic           prev_was_letter;
  logic           eom;
  logic [4:0]     pat;
  logic [2:0]     cnt;

  // Character decode, used only on the fetch step.
  logic           is_alpha, is_digit, is_letter, is_space;
  logic [5:0]     tbl_idx;
  mck_pkg::code_t code;

  // Segment about to be issued.
  logic       seg_level;
  logic [7:0] seg_dur;
  logic       seg_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_units <= mck_pkg::DashReset;
      letter_gap_units <= mck_pkg::LetterGapReset;
      word_gap_units <= mck_pkg::WordGapReset;
      pause_units <= mck_pkg::PauseReset;
    end else if (cfg.valid) begin
      case (mck_pkg::cfg_idx_t'(cfg.index))
        mck_pkg::CFG_DASH:       dash_units <= cfg.data[3:0];
        mck_pkg::CFG_LETTER_GAP: letter_gap_units <= cfg.data[3:0];
        mck_pkg::CFG_WORD_GAP:   word_gap_units <= cfg.data[4:0];
        mck_pkg::CFG_PAUSE:      pause_units <= cfg.data;
        default: ;
      endcase
    end
  end

  // Classify the incoming character and look up its code.
  always_comb begin
    is_alpha = (chars.character >= mck_pkg::CharUpperA) &&
               (chars.character <= mck_pkg::CharUpperZ);
    is_digit = (chars.character >= mck_pkg::CharZero) &&
               (chars.character <= mck_pkg::CharNine);
    is_letter = is_alpha || is_digit;
    is_space = (chars.character == mck_pkg::CharSpace);
    if (is_alpha) begin
      tbl_idx = 6'(chars.character - mck_pkg::CharUpperA);
    end else begin
      tbl_idx = 6'(chars.character - mck_pkg::CharZero + mck_pkg::DigitBase);
    end
    code = mck_pkg::mck_code(tbl_idx);
  end

  // Fetch the control word for the current step.
  assign cw = mck_pkg::mck_ucode(step);
  assign out_free = !segs.valid || segs.ready;
  assign chars.ready = (step == mck_pkg::S_FETCH);

  // Next step: hold until the step can complete, then branch.
  always_comb begin
    step_next = step;
    if (step == mck_pkg::S_FETCH) begin
      adv = chars.valid;
    end else if (cw.emit) begin
      adv = out_free;
    end else begin
      adv = 1'b1;
    end
    if (adv) begin
      case (cw.br)
        mck_pkg::BR_JUMP: begin
          step_next = cw.target;
        end
        mck_pkg::BR_DISPATCH: begin
          if (is_letter) begin
            step_next = prev_was_letter ? mck_pkg::S_LGAP : mck_pkg::S_ELEM;
          end else if (is_space) begin
            step_next = mck_pkg::S_SPACE;
          end else begin
            step_next = mck_pkg::S_EOMCHK;
          end
        end
        mck_pkg::BR_ELEM: begin
          // Loop back through an element gap while elements remain.
          step_next = (cnt != 3'd1) ? mck_pkg::S_EGAP : mck_pkg::S_EOMCHK;
        end
        mck_pkg::BR_EOM: begin
          step_next = eom ? mck_pkg::S_PAUSE : mck_pkg::S_FETCH;
        end
        default: begin
          step_next = mck_pkg::S_FETCH;
        end
      endcase
    end
  end

  // Segment fields selected by the control word.
  always_comb begin
    seg_level = cw.level;
    case (cw.dur)
      mck_pkg::DUR_ONE:   seg_dur = 8'd1;
      mck_pkg::DUR_ELEM:  seg_dur = pat[0] ? {4'd0, dash_units} : 8'd1;
      mck_pkg::DUR_LGAP:  seg_dur = {4'd0, letter_gap_units};
      mck_pkg::DUR_WGAP:  seg_dur = {3'd0, word_gap_units};
      mck_pkg::DUR_PAUSE: seg_dur = pause_units;
      default:            seg_dur = 8'd0;
    endcase
    case (cw.last_sel)
      mck_pkg::LAST_NEVER:  seg_last = 1'b0;
      mck_pkg::LAST_ELEM:   seg_last = (cnt == 3'd1) && !eom;
      mck_pkg::LAST_NO_EOM: seg_last = !eom;
      mck_pkg::LAST_ALWAYS: seg_last = 1'b1;
      default:              seg_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mck_pkg::S_FETCH;
      prev_was_letter <= 1'b0;
    end else begin
      step <= step_next;
      if (adv) begin
        case (cw.pwl)
          mck_pkg::PWL_CLASS: begin
            // Letter sets the flag, space clears it, anything else keeps it.
            if (is_letter) begin
              prev_was_letter <= 1'b1;
            end else if (is_space) begin
              prev_was_letter <= 1'b0;
            end
          end
          mck_pkg::PWL_CLEAR: prev_was_letter <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Latch the character on fetch; advance the element shifter per element.
  always_ff @(posedge clk) begin
    if (adv && step == mck_pkg::S_FETCH) begin
      eom <= chars.end_of_message;
      pat <= code.pat;
      cnt <= code.len;
    end else if (adv && step == mck_pkg::S_ELEM) begin
      pat <= pat >> 1;
      cnt <= cnt - 3'd1;
    end
  end

  // Output register: load a segment when the emitting step completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      segs.valid <= 1'b0;
    end else if (adv && cw.emit) begin
      segs.valid <= 1'b1;
    end else if (segs.ready) begin
      segs.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cw.emit) begin
      segs.level <= seg_level;
      segs.duration_units <= seg_dur;
      segs.last <= seg_last;
    end
  end

  // Hold a stalled segment until it is taken.
  `MCK_ASSERT_NXT(a_hold, segs.valid && !segs.ready, segs.valid && $stable(segs.duration_units))
  // Element steps always have an element left to send.
  `MCK_ASSERT_IMP(a_elem_count, step == mck_pkg::S_ELEM, cnt != 3'd0)
  // The pause ends the message, so no letter gap carries into the next one.
  `MCK_ASSERT_NXT(a_pause_clears, step == mck_pkg::S_PAUSE && adv, !prev_was_letter)

endmodule

@@ test/tb_morse_code_keyer.sv @@
module tb_morse_code_keyer;
  timeunit 1ns;
  timeprecision 1ps;

  // One character transaction as the sender queues it.
  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } char_item_t;

  // One key segment as the keyer should send it.
  typedef struct packed {
    logic       level;
    logic [7:0] dur;
    logic       last;
  } key_seg_t;

  logic clk;
  logic rst;

  mck_in_if  chars_ch();
  mck_out_if segs_ch();
  mck_cfg_if cfg_ch();

  morse_code_keyer uut (
    .clk  (clk),
    .rst  (rst),
    .chars(chars_ch),
    .segs (segs_ch),
    .cfg  (cfg_ch)
  );

  // Dots and dashes for A-Z followed by 0-9.
  string morse_codes [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....",
    "--...", "---..", "----."
  };

  // Our own copy of the timing registers and the letter-gap state.
  logic [3:0] dash_len;
  logic [3:0] lgap_len;
  logic [4:0] wgap_len;
  logic [7:0] pause_len;
  logic       after_letter;

  char_item_t chars_to_send [$];  // characters waiting for the driver
  key_seg_t   segs_due [$];       // segments predicted but not yet seen

  int chars_queued;
  int chars_taken;
  int errors;
  int src_idle_pct;
  int sink_stall_pct;
  logic chars_took;  // a character transaction completed at the last rising edge

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Predict the segments for one character and append them to segs_due.
  function automatic void encode_char(input logic [7:0] ch, input logic eom);
    key_seg_t run [$];
    string    code;
    int       slot;
    int       k;
    slot = -1;
    if (ch >= mck_pkg::CharUpperA && ch <= mck_pkg::CharUpperZ) begin
      slot = int'(ch - mck_pkg::CharUpperA);
    end else if (ch >= mck_pkg::CharZero && ch <= mck_pkg::CharNine) begin
      slot = int'(mck_pkg::DigitBase) + int'(ch - mck_pkg::CharZero);
    end
    if (slot >= 0) begin
      code = morse_codes[slot];
      // The gap between letters goes in front of the second one.
      if (after_letter) begin
        run.push_back(key_seg_t'{level: 1'b0, dur: {4'd0, lgap_len}, last: 1'b0});
      end
      for (k = 0; k < code.len(); k++) begin
        if (k > 0) begin
          run.push_back(key_seg_t'{level: 1'b0, dur: 8'd1, last: 1'b0});
        end
        run.push_back(key_seg_t'{level: 1'b1,
                                 dur: (code[k] == "-") ? {4'd0, dash_len} : 8'd1,
                                 last: 1'b0});
      end
      after_letter = 1'b1;
    end else if (ch == mck_pkg::CharSpace) begin
      run.push_back(key_seg_t'{level: 1'b0, dur: {3'd0, wgap_len}, last: 1'b0});
      after_letter = 1'b0;
    end
    // Unknown characters leave the letter-gap state alone.
    if (eom) begin
      run.push_back(key_seg_t'{level: 1'b0, dur: pause_len, last: 1'b0});
      after_letter = 1'b0;
    end
    if (run.size() > 0) begin
      run[run.size() - 1].last = 1'b1;
    end
    foreach (run[k]) begin
      segs_due.push_back(run[k]);
    end
  endfunction

  // Monitor: predict on every character transaction, check every segment transaction.
  always @(posedge clk) begin
    key_seg_t got;
    key_seg_t want;
    chars_took <= !rst && chars_ch.valid && chars_ch.ready;
    if (!rst) begin
      if (chars_ch.valid && chars_ch.ready) begin
        encode_char(chars_ch.character, chars_ch.end_of_message);
        chars_taken++;
      end
      if (segs_ch.valid && segs_ch.ready) begin
        got = '{level: segs_ch.level, dur: segs_ch.duration_units, last: segs_ch.last};
        if (segs_due.size() == 0) begin
          $display("%0t: unexpected segment: expected none, actual level %0b dur %0d last %0b",
                   $time, got.level, got.dur, got.last);
          errors++;
        end else begin
          want = segs_due.pop_front();
          if (got.level !== want.level) begin
            $display("%0t: level mismatch: expected %0b, actual %0b",
                     $time, want.level, got.level);
            errors++;
          end
          if (got.dur !== want.dur) begin
            $display("%0t: duration_units mismatch: expected %0d, actual %0d",
                     $time, want.dur, got.dur);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Driver: hold the current character until it is taken, then maybe advance.
  always @(negedge clk) begin
    char_item_t nxt;
    if (rst) begin
      chars_ch.valid <= 1'b0;
    end else if (!chars_ch.valid || chars_took) begin
      if (chars_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = chars_to_send.pop_front();
        chars_ch.valid <= 1'b1;
        chars_ch.character <= nxt.ch;
        chars_ch.end_of_message <= nxt.eom;
      end else begin
        chars_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall segs at the rate of the current phase.
  always @(negedge clk) begin
    segs_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic queue_char(input logic [7:0] ch, input logic eom);
    chars_to_send.push_back('{ch: ch, eom: eom});
    chars_queued++;
  endtask

  function automatic logic [7:0] pick_symbol();
    int n;
    n = $urandom_range(35);
    return (n < 26) ? mck_pkg::CharUpperA + 8'(n) : mck_pkg::CharZero + 8'(n - 26);
  endfunction

  // Mostly well-formed messages of random words, plus stray bytes and
  // messages whose end flag never comes.
  task automatic queue_random(input int target);
    char_item_t msg [$];
    int added;
    int nwords;
    int w;
    int k;
    logic [7:0] b;
    logic eom;
    added = 0;
    while (added < target) begin
      if ($urandom_range(99) < 25) begin
        b = 8'($urandom_range(255));
        eom = ($urandom_range(7) == 0);
        queue_char(b, eom);
        // Bytes that the keyer just drops do not count.
        if (eom || b == mck_pkg::CharSpace ||
            (b >= mck_pkg::CharUpperA && b <= mck_pkg::CharUpperZ) ||
            (b >= mck_pkg::CharZero && b <= mck_pkg::CharNine)) begin
          added++;
        end
      end else begin
        msg.delete();
        nwords = $urandom_range(1, 4);
        for (w = 0; w < nwords; w++) begin
          if (w > 0) begin
            msg.push_back('{ch: mck_pkg::CharSpace, eom: 1'b0});
            if ($urandom_range(9) == 0) begin
              msg.push_back('{ch: mck_pkg::CharSpace, eom: 1'b0});
            end
          end
          for (k = $urandom_range(1, 6); k > 0; k--) begin
            msg.push_back('{ch: pick_symbol(), eom: 1'b0});
          end
        end
        // Leave the end flag off now and then.
        if ($urandom_range(9) != 0) begin
          msg[msg.size() - 1].eom = 1'b1;
        end
        foreach (msg[k]) begin
          queue_char(msg[k].ch, msg[k].eom);
        end
        added += msg.size();
      end
    end
  endtask

  // Wait for every character to be taken and every segment to arrive, then
  // give an unknown character the cycles it may still be busy with.
  task automatic drain();
    while (chars_taken != chars_queued || segs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input mck_pkg::cfg_idx_t r, input logic [7:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    case (r)
      mck_pkg::CFG_DASH:       dash_len = v[3:0];
      mck_pkg::CFG_LETTER_GAP: lgap_len = v[3:0];
      mck_pkg::CFG_WORD_GAP:   wgap_len = v[4:0];
      mck_pkg::CFG_PAUSE:      pause_len = v;
      default: ;
    endcase
  endtask

  // Write all four timing registers back to back, then drop valid.
  task automatic set_timing(input logic [7:0] d, input logic [7:0] l,
                            input logic [7:0] w, input logic [7:0] p);
    write_reg(mck_pkg::CFG_DASH, d);
    write_reg(mck_pkg::CFG_LETTER_GAP, l);
    write_reg(mck_pkg::CFG_WORD_GAP, w);
    write_reg(mck_pkg::CFG_PAUSE, p);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    chars_ch.valid = 1'b0;
    chars_ch.character = 8'd0;
    chars_ch.end_of_message = 1'b0;
    segs_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mck_pkg::CFG_DASH;
    cfg_ch.data = 8'd0;
    chars_took = 1'b0;
    dash_len = mck_pkg::DashReset;
    lgap_len = mck_pkg::LetterGapReset;
    wgap_len = mck_pkg::WordGapReset;
    pause_len = mck_pkg::PauseReset;
    after_letter = 1'b0;
    chars_queued = 0;
    chars_taken = 0;
    errors = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset timing, no idling: table ends, letter gaps,
    // unknown bytes with and without the end flag, spaces ending a message.
    queue_char("A", 1'b0);
    queue_char("Z", 1'b0);
    queue_char("0", 1'b0);
    queue_char("9", 1'b1);
    queue_char(" ", 1'b0);
    queue_char("E", 1'b0);
    queue_char("a", 1'b0);  // dropped, so the gap still goes before T
    queue_char("T", 1'b0);
    queue_char(" ", 1'b1);
    queue_char(8'h00, 1'b1);  // pause alone
    queue_char(8'hFF, 1'b0);
    queue_char("S", 1'b0);
    queue_char("O", 1'b0);
    queue_char("S", 1'b1);
    drain();

    // Hold the sender until all of the above has come out, then go on.
    queue_char("Q", 1'b0);
    queue_char("5", 1'b1);
    queue_char(" ", 1'b0);
    queue_char(" ", 1'b0);
    queue_char("K", 1'b0);
    queue_char(8'h7F, 1'b1);
    queue_random(45);
    drain();

    // Largest timing, sender mostly idle.
    set_timing(8'd15, 8'd15, 8'd31, 8'd255);
    src_idle_pct = 66;
    sink_stall_pct = 0;
    queue_random(45);
    drain();

    // Smallest legal timing with a zero pause, receiver mostly stalled.
    set_timing(8'd1, 8'd1, 8'd1, 8'd0);
    src_idle_pct = 0;
    sink_stall_pct = 66;
    queue_random(45);
    drain();

    // Values past the field widths: only the low bits stay, zeros included.
    set_timing(8'hF0, 8'h17, 8'hE0, 8'h80);
    src_idle_pct = 15;
    sink_stall_pct = 15;
    queue_random(45);
    drain();

    // Random timing to finish.
    set_timing(8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
    queue_random(40);
    drain();

    if (errors == 0) begin
      $display("tb_morse_code_keyer: PASS");
    end else begin
      $display("tb_morse_code_keyer: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("tb_morse_code_keyer: FAIL");
    $finish;
  end

endmodule
